// File: hw/rtl/proximity_dispense_controller_defines.svh
// Assertion macros used by the dispenser controller top level.
`ifndef PROXIMITY_DISPENSE_CONTROLLER_DEFINES_SVH
`define PROXIMITY_DISPENSE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdc assertion failed");

`endif

// File: hw/rtl/pdc_pkg.sv
// Shared types and constants of the dispenser controller.
`default_nettype none

package pdc_pkg;

    localparam int DIST_W      = 12;
    localparam int TIME_W      = 32;
    localparam int CH_W        = 2;
    localparam int MASK_W      = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Command codes of an input word.
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVATE_NEAR_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVATE_FLOOR      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_DISTANCE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_CEILING     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COOL_OFF_MS         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DISPENSE_MS         = 3'd5;

    // Configuration register file contents.
    typedef struct packed {
        logic [DIST_W-1:0] activate_near_limit;
        logic [DIST_W-1:0] activate_floor;
        logic [DIST_W-1:0] release_distance;
        logic [DIST_W-1:0] release_ceiling;
        logic [TIME_W-1:0] cool_off_ms;
        logic [TIME_W-1:0] dispense_ms;
    } cfg_t;

    // Word being processed, broadcast to every channel.
    typedef struct packed {
        logic              step;
        logic              tick;
        logic [DIST_W-1:0] distance_mm;
        logic [TIME_W-1:0] now_ms;
    } item_ctl_t;

    // Per-channel outcome of the word being processed.
    typedef struct packed {
        logic valve;
        logic started;
        logic stopped;
    } chan_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/proximity_dispense_controller.sv
// Top level of the multi-channel touchless dispenser controller.
// The block takes one word per cycle while item_stall is low and returns one result word per
// input word: a tick advances the millisecond clock and times out running dispenses, a distance
// sample may start or stop the valve of its channel. A word is held in an input register, all
// channels compute their update from it, and the result lands in an output register when the
// word advances, so a new word can be taken while the last result waits in the output register.
// The input side stalls only while both registers are full and the receiver holds the result.
// Configuration writes are always ready and take effect at once, so they must only be issued
// while no word is in flight.
`default_nettype none

`include "proximity_dispense_controller_defines.svh"

module proximity_dispense_controller #(
    parameter int CHANNELS = 4
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Input words
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire logic                             cmd,
    input  wire logic [pdc_pkg::CH_W-1:0]         channel,
    input  wire logic [pdc_pkg::DIST_W-1:0]       distance_mm,
    // Result words
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output logic [pdc_pkg::MASK_W-1:0]            valve_states,
    output logic [pdc_pkg::MASK_W-1:0]            started_mask,
    output logic [pdc_pkg::MASK_W-1:0]            stopped_mask,
    // Configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [pdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pdc_pkg::*;

    cfg_t              cfg_reg;
    logic              in_valid_reg, in_valid_next;
    logic              cmd_reg;
    logic [CH_W-1:0]   channel_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [TIME_W-1:0] now_ms_reg;
    logic [TIME_W-1:0] now_cur;
    logic              out_valid_reg, out_valid_next;
    logic [MASK_W-1:0] valve_reg, started_reg, stopped_reg;
    logic [MASK_W-1:0] valve_vec, started_vec, stopped_vec;
    logic              accept;
    logic              adv;
    item_ctl_t         ctl;
    chan_status_t      status [CHANNELS];

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.activate_near_limit <= 12'd100;
            cfg_reg.activate_floor      <= 12'd20;
            cfg_reg.release_distance    <= 12'd150;
            cfg_reg.release_ceiling     <= 12'd4000;
            cfg_reg.cool_off_ms         <= 32'd2000;
            cfg_reg.dispense_ms         <= 32'd5000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACTIVATE_NEAR_LIMIT: cfg_reg.activate_near_limit <= cfg_data[DIST_W-1:0];
                REG_ACTIVATE_FLOOR:      cfg_reg.activate_floor      <= cfg_data[DIST_W-1:0];
                REG_RELEASE_DISTANCE:    cfg_reg.release_distance    <= cfg_data[DIST_W-1:0];
                REG_RELEASE_CEILING:     cfg_reg.release_ceiling     <= cfg_data[DIST_W-1:0];
                REG_COOL_OFF_MS:         cfg_reg.cool_off_ms         <= cfg_data[TIME_W-1:0];
                REG_DISPENSE_MS:         cfg_reg.dispense_ms         <= cfg_data[TIME_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Handshake: the held word advances whenever the result register can take it.
    assign adv            = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall     = in_valid_reg && !adv;
    assign accept         = item_valid && !item_stall;
    assign in_valid_next  = accept || (in_valid_reg && !adv);
    assign out_valid_next = adv || (out_valid_reg && result_stall);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd;
            channel_reg <= channel;
            dist_reg    <= distance_mm;
        end
    end

    // Millisecond clock; a tick sees the advanced time.
    assign now_cur = (cmd_reg == CMD_TICK) ? now_ms_reg + 32'd1 : now_ms_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_ms_reg <= '0;
        end
        else if (adv && (cmd_reg == CMD_TICK))
        begin
            now_ms_reg <= now_cur;
        end
    end

    assign ctl.step        = adv;
    assign ctl.tick        = (cmd_reg == CMD_TICK);
    assign ctl.distance_mm = dist_reg;
    assign ctl.now_ms      = now_cur;

    // One update unit per channel; samples reach only channels the index field can name.
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_chan
        logic hit;
        assign hit = (cmd_reg == CMD_SAMPLE) && (32'(channel_reg) == i);
        pdc_channel u_chan (
            .clk    (clk),
            .rst_n  (rst_n),
            .cfg    (cfg_reg),
            .ctl    (ctl),
            .hit    (hit),
            .status (status[i])
        );
    end

    // Only the first four channels appear in the result fields.
    for (genvar j = 0; j < MASK_W; j++)
    begin : g_mask
        if (j < CHANNELS)
        begin : g_used
            assign valve_vec[j]   = status[j].valve;
            assign started_vec[j] = status[j].started;
            assign stopped_vec[j] = status[j].stopped;
        end
        else
        begin : g_unused
            assign valve_vec[j]   = 1'b0;
            assign started_vec[j] = 1'b0;
            assign stopped_vec[j] = 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            valve_reg   <= valve_vec;
            started_reg <= started_vec;
            stopped_reg <= stopped_vec;
        end
    end

    assign result_valid = out_valid_reg;
    assign valve_states = valve_reg;
    assign started_mask = started_reg;
    assign stopped_mask = stopped_reg;

    // Checks on the update logic and the stage handshake.
    `PDC_ASSERT_NOW(a_stop_closes, clk, rst_n, out_valid_reg, (stopped_reg & valve_reg) == '0)
    `PDC_ASSERT_NOW(a_start_opens, clk, rst_n, out_valid_reg,
                    (started_reg & ~stopped_reg & ~valve_reg) == '0)
    `PDC_ASSERT_NEXT(a_tick_no_start, clk, rst_n, adv && (cmd_reg == CMD_TICK),
                     started_reg == '0)
    `PDC_ASSERT_NOW(a_stall_full, clk, rst_n, item_stall, in_valid_reg && out_valid_reg)

endmodule

`default_nettype wire

// File: hw/rtl/pdc_channel.sv
// State and update logic of one dispenser channel.
`default_nettype none

module pdc_channel (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pdc_pkg::cfg_t        cfg,
    input  wire pdc_pkg::item_ctl_t   ctl,
    input  wire logic                 hit,
    output pdc_pkg::chan_status_t     status
);
    import pdc_pkg::*;

    logic              valve_reg, valve_next;
    logic              latch_reg, latch_next;
    logic              run_reg, run_next;
    logic [TIME_W-1:0] tstart_reg, tstart_next;
    logic [TIME_W-1:0] cstart_reg, cstart_next;
    logic              started, stopped;

    logic              activate;
    logic              in_release;
    logic              far;
    logic              cool_ok;
    logic              timed_out;
    logic [TIME_W-1:0] run_time;
    logic [TIME_W-1:0] cool_time;

    // Distance and elapsed-time tests, all modulo 2^32 for the times.
    assign activate   = (ctl.distance_mm <= cfg.activate_near_limit) &&
                        (ctl.distance_mm >  cfg.activate_floor);
    assign far        = (ctl.distance_mm >= cfg.release_distance);
    assign in_release = far && (ctl.distance_mm < cfg.release_ceiling);
    assign run_time   = ctl.now_ms - tstart_reg;
    assign cool_time  = ctl.now_ms - cstart_reg;
    assign timed_out  = (run_time >= cfg.dispense_ms);
    assign cool_ok    = (cool_time >= cfg.cool_off_ms);

    // Next state: a tick checks the timeout, a sample runs start, removal and latch steps.
    always_comb
    begin
        valve_next  = valve_reg;
        latch_next  = latch_reg;
        run_next    = run_reg;
        tstart_next = tstart_reg;
        cstart_next = cstart_reg;
        started     = 1'b0;
        stopped     = 1'b0;
        if (ctl.tick)
        begin
            if (run_reg && timed_out)
            begin
                valve_next  = 1'b0;
                run_next    = 1'b0;
                cstart_next = ctl.now_ms;
                stopped     = 1'b1;
            end
        end
        else if (hit)
        begin
            if (activate)
            begin
                if (!valve_reg && cool_ok && !latch_reg)
                begin
                    latch_next  = 1'b1;
                    valve_next  = 1'b1;
                    run_next    = 1'b1;
                    tstart_next = ctl.now_ms;
                    started     = 1'b1;
                end
            end
            else if (in_release && valve_reg)
            begin
                valve_next  = 1'b0;
                run_next    = 1'b0;
                cstart_next = ctl.now_ms;
                stopped     = 1'b1;
            end
            if (latch_next && far)
            begin
                latch_next = 1'b0;
                if (valve_next)
                begin
                    valve_next  = 1'b0;
                    run_next    = 1'b0;
                    cstart_next = ctl.now_ms;
                    stopped     = 1'b1;
                end
            end
        end
    end

    // Channel state advances when the word moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valve_reg  <= 1'b0;
            latch_reg  <= 1'b0;
            run_reg    <= 1'b0;
            tstart_reg <= '0;
            cstart_reg <= '0;
        end
        else if (ctl.step)
        begin
            valve_reg  <= valve_next;
            latch_reg  <= latch_next;
            run_reg    <= run_next;
            tstart_reg <= tstart_next;
            cstart_reg <= cstart_next;
        end
    end

    assign status.valve   = valve_next;
    assign status.started = started;
    assign status.stopped = stopped;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the touchless dispenser controller: predicts every result word.

module tb;

    import pdc_pkg::*;

    // Expected contents of one result word.
    typedef struct packed {
        logic [MASK_W-1:0] valves;
        logic [MASK_W-1:0] started;
        logic [MASK_W-1:0] stopped;
    } outcome_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    logic                   cmd = CMD_TICK;
    logic [CH_W-1:0]        channel = '0;
    logic [DIST_W-1:0]      distance_mm = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [MASK_W-1:0]      valve_states;
    logic [MASK_W-1:0]      started_mask;
    logic [MASK_W-1:0]      stopped_mask;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_ACTIVATE_NEAR_LIMIT;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Traffic shaping and bookkeeping.
    int tx_idle_pct = 22;
    int rx_idle_pct = 65;
    logic rx_hold = 1'b0;
    int error_count = 0;
    int words_sent = 0;
    outcome_t pending_outcomes[$];

    // Shadow of the controller's registers and per-channel state.
    cfg_t              regs_q;
    logic [TIME_W-1:0] clock_ms;
    logic [3:0]        open_q;
    logic [3:0]        latched_q;
    logic [3:0]        running_q;
    logic [TIME_W-1:0] run_since [4];
    logic [TIME_W-1:0] rest_since [4];

    proximity_dispense_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .channel      (channel),
        .distance_mm  (distance_mm),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .valve_states (valve_states),
        .started_mask (started_mask),
        .stopped_mask (stopped_mask),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Power-on values of the shadow state.
    initial
    begin
        regs_q.activate_near_limit = 12'd100;
        regs_q.activate_floor      = 12'd20;
        regs_q.release_distance    = 12'd150;
        regs_q.release_ceiling     = 12'd4000;
        regs_q.cool_off_ms         = 32'd2000;
        regs_q.dispense_ms         = 32'd5000;
        clock_ms  = '0;
        open_q    = '0;
        latched_q = '0;
        running_q = '0;
        for (int i = 0; i < 4; i++)
        begin
            run_since[i]  = '0;
            rest_since[i] = '0;
        end
    end

    // Any stop closes the valve and restarts the channel's cool-off.
    function automatic void shut_channel(input int c);
        open_q[c]     = 1'b0;
        running_q[c]  = 1'b0;
        rest_since[c] = clock_ms;
    endfunction

    // Advance the shadow state by one accepted word and return the result it causes.
    function automatic outcome_t dispense_step(input logic c, input logic [CH_W-1:0] ch,
                                               input logic [DIST_W-1:0] d);
        outcome_t r;
        logic [TIME_W-1:0] elapsed;
        r = '0;
        if (c == CMD_TICK)
        begin
            clock_ms = clock_ms + 32'd1;
            for (int i = 0; i < 4; i++)
            begin
                elapsed = clock_ms - run_since[i];
                if (running_q[i] && elapsed >= regs_q.dispense_ms)
                begin
                    shut_channel(i);
                    r.stopped[i] = 1'b1;
                end
            end
        end
        else
        begin
            elapsed = clock_ms - rest_since[ch];
            if (d <= regs_q.activate_near_limit && d > regs_q.activate_floor)
            begin
                if (!open_q[ch] && elapsed >= regs_q.cool_off_ms && !latched_q[ch])
                begin
                    latched_q[ch] = 1'b1;
                    open_q[ch]    = 1'b1;
                    running_q[ch] = 1'b1;
                    run_since[ch] = clock_ms;
                    r.started[ch] = 1'b1;
                end
            end
            else if (d >= regs_q.release_distance && d < regs_q.release_ceiling && open_q[ch])
            begin
                shut_channel(ch);
                r.stopped[ch] = 1'b1;
            end
            // A hand that moved away releases the latch and stops a valve still open.
            if (latched_q[ch] && d >= regs_q.release_distance)
            begin
                latched_q[ch] = 1'b0;
                if (open_q[ch])
                begin
                    shut_channel(ch);
                    r.stopped[ch] = 1'b1;
                end
            end
        end
        r.valves = open_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [MASK_W-1:0] want,
                               input logic [MASK_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            error_count++;
        end
    endtask

    // Result side: check each accepted word, then pick the next stall value.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result word with nothing expected: valves %h started %h stopped %h",
                       valve_states, started_mask, stopped_mask);
                error_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("valve_states", want.valves, valve_states);
                check_field("started_mask", want.started, started_mask);
                check_field("stopped_mask", want.stopped, stopped_mask);
            end
        end
        result_stall <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);
    end

    // Offer one word, hold it until accepted, then record its expected result.
    task automatic send_word(input logic c, input logic [CH_W-1:0] ch,
                             input logic [DIST_W-1:0] d);
        outcome_t o;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid  <= 1'b1;
        cmd         <= c;
        channel     <= ch;
        distance_mm <= d;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        o = dispense_step(c, ch, d);
        pending_outcomes.push_back(o);
        words_sent++;
    endtask

    // Stop offering words and let every outstanding result drain.
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // One register write; the caller lowers cfg_valid after the last one.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_ACTIVATE_NEAR_LIMIT: regs_q.activate_near_limit = v[DIST_W-1:0];
            REG_ACTIVATE_FLOOR:      regs_q.activate_floor      = v[DIST_W-1:0];
            REG_RELEASE_DISTANCE:    regs_q.release_distance    = v[DIST_W-1:0];
            REG_RELEASE_CEILING:     regs_q.release_ceiling     = v[DIST_W-1:0];
            REG_COOL_OFF_MS:         regs_q.cool_off_ms         = v;
            REG_DISPENSE_MS:         regs_q.dispense_ms         = v;
            default: ;
        endcase
    endtask

    task automatic load_settings(input cfg_t s);
        wait_idle();
        write_reg(REG_ACTIVATE_NEAR_LIMIT, CFG_DATA_W'(s.activate_near_limit));
        write_reg(REG_ACTIVATE_FLOOR, CFG_DATA_W'(s.activate_floor));
        write_reg(REG_RELEASE_DISTANCE, CFG_DATA_W'(s.release_distance));
        write_reg(REG_RELEASE_CEILING, CFG_DATA_W'(s.release_ceiling));
        write_reg(REG_COOL_OFF_MS, s.cool_off_ms);
        write_reg(REG_DISPENSE_MS, s.dispense_ms);
        cfg_valid <= 1'b0;
    endtask

    // Distances biased toward the band and threshold edges of the current settings.
    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(0, 9))
            0: return regs_q.activate_near_limit;
            1: return regs_q.activate_near_limit + 12'd1;
            2: return regs_q.activate_floor;
            3: return regs_q.activate_floor + 12'd1;
            4: return regs_q.release_distance;
            5: return regs_q.release_distance - 12'd1;
            6: return regs_q.release_ceiling;
            7: return regs_q.release_ceiling - 12'd1;
            8: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            default: return DIST_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [DIST_W-1:0] band_distance();
        if (regs_q.activate_near_limit > regs_q.activate_floor)
            return DIST_W'($urandom_range(int'(regs_q.activate_floor) + 1,
                                          int'(regs_q.activate_near_limit)));
        return pick_distance();
    endfunction

    function automatic logic [DIST_W-1:0] away_distance();
        if (regs_q.release_distance < regs_q.release_ceiling && $urandom_range(0, 1))
            return DIST_W'($urandom_range(int'(regs_q.release_distance),
                                          int'(regs_q.release_ceiling) - 1));
        return DIST_W'($urandom_range(int'(regs_q.release_distance), 4095));
    endfunction

    task automatic noise_word();
        if ($urandom_range(0, 1))
            send_word(CMD_TICK, CH_W'($urandom_range(0, 3)), DIST_W'($urandom_range(0, 4095)));
        else
            send_word(CMD_SAMPLE, CH_W'($urandom_range(0, 3)), pick_distance());
    endtask

    // A hand approaches one channel, lingers while time passes, then leaves.
    task automatic hand_visit();
        logic [CH_W-1:0] ch;
        int linger;
        ch = CH_W'($urandom_range(0, 3));
        linger = $urandom_range(0, 12);
        send_word(CMD_SAMPLE, ch, band_distance());
        repeat (linger)
        begin
            case ($urandom_range(0, 3))
                0, 1: send_word(CMD_TICK, CH_W'($urandom_range(0, 3)),
                                DIST_W'($urandom_range(0, 4095)));
                2:    send_word(CMD_SAMPLE, ch, band_distance());
                default: send_word(CMD_SAMPLE, CH_W'($urandom_range(0, 3)), pick_distance());
            endcase
        end
        send_word(CMD_SAMPLE, ch, away_distance());
    endtask

    // Register sets of the random phases: the first three sit at the extremes.
    function automatic cfg_t phase_settings(input int p);
        cfg_t s;
        case (p)
            0:
            begin
                s.activate_near_limit = 12'hFFF;
                s.activate_floor      = 12'h000;
                s.release_distance    = 12'h000;
                s.release_ceiling     = 12'hFFF;
                s.cool_off_ms         = 32'd0;
                s.dispense_ms         = 32'd1;
            end
            1:
            begin
                s.activate_near_limit = 12'hFFF;
                s.activate_floor      = 12'h000;
                s.release_distance    = 12'hFFF;
                s.release_ceiling     = 12'h000;
                s.cool_off_ms         = 32'd0;
                s.dispense_ms         = 32'hFFFF_FFFF;
            end
            2:
            begin
                s.activate_near_limit = 12'h000;
                s.activate_floor      = 12'hFFF;
                s.release_distance    = 12'h000;
                s.release_ceiling     = 12'h000;
                s.cool_off_ms         = 32'hFFFF_FFFF;
                s.dispense_ms         = 32'd0;
            end
            default:
            begin
                s.activate_near_limit = DIST_W'($urandom_range(10, 400));
                s.activate_floor      = DIST_W'($urandom_range(0,
                                                int'(s.activate_near_limit) - 1));
                // Sometimes the release threshold sits inside the band.
                if ($urandom_range(0, 2) == 0)
                    s.release_distance = DIST_W'($urandom_range(int'(s.activate_floor),
                                                 int'(s.activate_near_limit)));
                else
                    s.release_distance = DIST_W'($urandom_range(int'(s.activate_near_limit) + 1,
                                                 int'(s.activate_near_limit) + 200));
                if ($urandom_range(0, 3) != 0)
                    s.release_ceiling = DIST_W'($urandom_range(int'(s.release_distance) + 1,
                                                               4095));
                else
                    s.release_ceiling = DIST_W'($urandom_range(0, 4095));
                s.cool_off_ms = $urandom_range(0, 12);
                s.dispense_ms = $urandom_range(0, 20);
            end
        endcase
        return s;
    endfunction

    // Right after reset the cool-off has not elapsed, so nothing may start.
    task automatic test_reset_cool_off();
        send_word(CMD_SAMPLE, 2'd0, 12'd50);
        send_word(CMD_SAMPLE, 2'd3, 12'hFFF);
        send_word(CMD_TICK, 2'd0, 12'd0);
        send_word(CMD_SAMPLE, 2'd1, 12'h000);
        send_word(CMD_SAMPLE, 2'd2, 12'd100);
    endtask

    // Start, latch, timeout, early removal and the band edges with ordinary settings.
    task automatic test_timed_dispense();
        cfg_t s;
        s.activate_near_limit = 12'd100;
        s.activate_floor      = 12'd20;
        s.release_distance    = 12'd150;
        s.release_ceiling     = 12'd4000;
        s.cool_off_ms         = 32'd0;
        s.dispense_ms         = 32'd3;
        load_settings(s);
        send_word(CMD_SAMPLE, 2'd0, 12'd50);
        send_word(CMD_SAMPLE, 2'd0, 12'd50);
        repeat (3) send_word(CMD_TICK, 2'd0, 12'd0);
        send_word(CMD_SAMPLE, 2'd0, 12'd60);
        send_word(CMD_SAMPLE, 2'd0, 12'd200);
        send_word(CMD_SAMPLE, 2'd0, 12'd60);
        send_word(CMD_SAMPLE, 2'd0, 12'd200);
        send_word(CMD_SAMPLE, 2'd2, 12'd20);
        send_word(CMD_SAMPLE, 2'd2, 12'd21);
        send_word(CMD_SAMPLE, 2'd3, 12'd100);
        send_word(CMD_SAMPLE, 2'd3, 12'hFFF);
    endtask

    // Release threshold inside the band: one sample starts and stops a channel.
    task automatic test_crossed_band();
        cfg_t s;
        s.activate_near_limit = 12'd300;
        s.activate_floor      = 12'd0;
        s.release_distance    = 12'd100;
        s.release_ceiling     = 12'hFFF;
        s.cool_off_ms         = 32'd0;
        s.dispense_ms         = 32'd0;
        load_settings(s);
        send_word(CMD_SAMPLE, 2'd1, 12'd200);
        send_word(CMD_TICK, 2'd1, 12'd0);
        send_word(CMD_SAMPLE, 2'd1, 12'd50);
        send_word(CMD_TICK, 2'd3, 12'hFFF);
        send_word(CMD_SAMPLE, 2'd1, 12'hFFF);
    endtask

    // Random hand visits and noise over several register sets and idle patterns.
    task automatic test_random_phases();
        int first;
        for (int p = 0; p < 8; p++)
        begin
            if (p < 3)
            begin
                tx_idle_pct = 22;
                rx_idle_pct <= 65;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 65;
                rx_idle_pct <= 22;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            load_settings(phase_settings(p));
            first = words_sent;
            while (words_sent - first < 150)
            begin
                if ($urandom_range(0, 3) != 0)
                    hand_visit();
                else
                    noise_word();
            end
        end
    endtask

    // The receiver holds off long enough for the block to back up into its input.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (60) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (40) noise_word();
        // Pause the sender until everything outstanding has come back.
        wait_idle();
        repeat (10) hand_visit();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_cool_off();
        test_timed_dispense();
        test_crossed_band();
        test_random_phases();
        test_backpressure();
        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("PASS proximity_dispense_controller");
        else
            $display("FAIL proximity_dispense_controller");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("FAIL proximity_dispense_controller");
        $finish;
    end

endmodule

// File: proximity_dispense_controller.f
+incdir+hw/rtl
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_channel.sv
hw/rtl/proximity_dispense_controller.sv
tb/sv/tb.sv
